// ===== src/msu_pkg.sv =====
// Shared types, byte codes and the attachment marker table for the preview unit.
`default_nettype none

package msu_pkg;

  localparam int unsigned MARKER_LEN = 18;

  localparam logic [7:0] CHAR_LIMIT_RESET = 8'd35;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [2:0] {
    MODE_COPY  = 3'd0,
    MODE_TAG   = 3'd1,
    MODE_MATCH = 3'd2,
    MODE_SKIP  = 3'd3,
    MODE_DONE  = 3'd4
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic [4:0]  midx;   // marker bytes matched
    logic [2:0]  cont;   // continuation bytes left
    logic [7:0]  count;  // counted characters
  } parse_state_t;

  // What one request produces: replayed marker letters, then an optional tail byte.
  typedef struct packed {
    logic [4:0]  replay_n;
    logic        tail_valid;
    logic [7:0]  tail_byte;
    logic        done;
    logic [7:0]  count;
  } result_desc_t;

  // "\nbeginbinaryattach"
  function automatic logic [7:0] marker_byte(logic [4:0] idx);
    logic [7:0] r;
    unique case (idx)
      5'd0:    r = 8'h0A;
      5'd1:    r = 8'h62; // b
      5'd2:    r = 8'h65; // e
      5'd3:    r = 8'h67; // g
      5'd4:    r = 8'h69; // i
      5'd5:    r = 8'h6E; // n
      5'd6:    r = 8'h62; // b
      5'd7:    r = 8'h69; // i
      5'd8:    r = 8'h6E; // n
      5'd9:    r = 8'h61; // a
      5'd10:   r = 8'h72; // r
      5'd11:   r = 8'h79; // y
      5'd12:   r = 8'h61; // a
      5'd13:   r = 8'h74; // t
      5'd14:   r = 8'h74; // t
      5'd15:   r = 8'h61; // a
      5'd16:   r = 8'h63; // c
      5'd17:   r = 8'h68; // h
      default: r = CH_NUL;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/markup_strip_utf8_preview_unit.sv =====
// Top level of the markup-stripping UTF-8 text preview unit.
`default_nettype none

// Takes source text one byte per request and returns the bytes of a short plain-text
// preview: tags from '<' to '>' are dropped, as are CR, LF and the bytes { } [ ],
// a line that starts with the attachment marker is skipped to the next newline, and
// UTF-8 characters are copied whole. Multibyte characters and spaces are counted;
// the preview ends when the count reaches char_limit, at a zero byte or at tlast.
// Every input request yields at least one output request (byte_valid 0 if nothing
// was copied); tlast marks the last one. Rate: one byte per cycle when each byte
// yields one result and the output is not stalled, which is the usual case. A byte
// that breaks a partial marker match replays the held letters: one result per letter,
// plus one if the byte is copied, at most 17. Only the result serializer iterates,
// and the input stalls behind it. Bytes pass the input register, then the result
// register. tuser bit 0 of the input is first_byte, which restarts parsing.
// The char_limit register (reset 35) may be written only while the unit is idle.
module markup_strip_utf8_preview_unit
  import msu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write: char_limit
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tuser,   // [0] first_byte
  input  logic        s_axis_tlast,   // last_byte
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [15:8] char_count
  output logic [1:0]  m_axis_tuser,   // [0] byte_valid, [1] preview_done
  output logic        m_axis_tlast    // run_last
);

  logic [7:0]   char_limit_q;

  // input register
  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         in_first_q;
  logic         in_last_q;

  // parse state, committed when a byte moves into the result register
  parse_state_t state_q;
  parse_state_t state_d;
  result_desc_t desc;

  logic         emit_can_load;
  logic         load;
  logic         in_accept;

  logic [7:0]   out_byte;
  logic         out_byte_valid;
  logic         out_done;
  logic [7:0]   out_count;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_limit_q <= CHAR_LIMIT_RESET;
    end else if (cfg_valid_i) begin
      char_limit_q <= cfg_data_i;
    end
  end

  assign load          = in_valid_q && emit_can_load;
  assign s_axis_tready = !in_valid_q || load;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (load) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q  <= s_axis_tdata;
      in_first_q <= s_axis_tuser;
      in_last_q  <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode  <= MODE_COPY;
      state_q.midx  <= 5'd0;
      state_q.cont  <= 3'd0;
      state_q.count <= 8'd0;
    end else if (load) begin
      state_q <= state_d;
    end
  end

  msu_parse u_parse (
    .state_i (state_q),
    .limit_i (char_limit_q),
    .byte_i  (in_byte_q),
    .first_i (in_first_q),
    .last_i  (in_last_q),
    .state_o (state_d),
    .desc_o  (desc)
  );

  msu_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .desc_i       (desc),
    .can_load_o   (emit_can_load),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .byte_o       (out_byte),
    .byte_valid_o (out_byte_valid),
    .last_o       (m_axis_tlast),
    .done_o       (out_done),
    .count_o      (out_count)
  );

  assign m_axis_tdata = {out_count, out_byte};
  assign m_axis_tuser = {out_done, out_byte_valid};

endmodule

`default_nettype wire

// ===== src/msu_parse.sv =====
// Next-state and result-descriptor logic for one text byte.
`default_nettype none

module msu_parse
  import msu_pkg::*;
(
  input  parse_state_t state_i,
  input  logic [7:0]   limit_i,
  input  logic [7:0]   byte_i,
  input  logic         first_i,
  input  logic         last_i,
  output parse_state_t state_o,
  output result_desc_t desc_o
);

  typedef struct packed {
    parse_state_t st;
    logic         emit;
  } copy_t;

  typedef struct packed {
    parse_state_t st;
    logic [4:0]   n;
  } replay_t;

  function automatic logic [7:0] count_inc(logic [7:0] c);
    return (c != 8'hFF) ? c + 8'd1 : c;
  endfunction

  // continuation bytes following a lead byte (length capped at six)
  function automatic logic [2:0] utf8_cont(logic [7:0] b);
    logic [2:0] r;
    priority if (!b[5]) r = 3'd1;
    else if (!b[4])     r = 3'd2;
    else if (!b[3])     r = 3'd3;
    else if (!b[2])     r = 3'd4;
    else                r = 3'd5;
    return r;
  endfunction

  function automatic copy_t copy_byte(parse_state_t s, logic [7:0] b, logic [7:0] lim);
    copy_t r;
    logic  stop;
    r.st   = s;
    r.emit = 1'b0;
    stop   = 1'b0;
    if (s.cont != 3'd0) begin
      if (b == CH_NUL) begin
        r.st.cont = 3'd0;
        r.st.mode = MODE_DONE;
        stop      = 1'b1;
      end else begin
        r.emit    = 1'b1;
        r.st.cont = s.cont - 3'd1;
      end
    end else if (s.count >= lim || b == CH_NUL) begin
      r.st.mode = MODE_DONE;
      stop      = 1'b1;
    end else if (b == CH_LT) begin
      r.st.mode = MODE_TAG;
      stop      = 1'b1;
    end else if (b == CH_LF) begin
      r.st.mode = MODE_MATCH;
      r.st.midx = 5'd1;
      stop      = 1'b1;
    end else if (b == CH_CR || b == CH_LBRACE || b == CH_RBRACE ||
                 b == CH_LBRACK || b == CH_RBRACK) begin
      stop = 1'b1;
    end else begin
      r.emit = 1'b1;
      if (b[7:6] == 2'b11) begin
        r.st.count = count_inc(s.count);
        r.st.cont  = utf8_cont(b);
      end else if (b == CH_SPACE) begin
        r.st.count = count_inc(s.count);
      end
    end
    if (!stop && r.st.mode == MODE_COPY && r.st.cont == 3'd0 && r.st.count >= lim) begin
      r.st.mode = MODE_DONE;
    end
    return r;
  endfunction

  // Held marker letters are plain ASCII: all go out unless the limit is already hit.
  function automatic replay_t replay(parse_state_t s, logic [4:0] held, logic [7:0] lim);
    replay_t r;
    r.st = s;
    r.n  = 5'd0;
    if (held >= 5'd2) begin
      if (s.count >= lim) begin
        r.st.mode = MODE_DONE;
      end else if (held > 5'(MARKER_LEN)) begin
        r.n = 5'(MARKER_LEN - 1);
      end else begin
        r.n = held - 5'd1;
      end
    end
    return r;
  endfunction

  always_comb begin
    parse_state_t s;
    copy_t        c;
    replay_t      rp;
    logic [4:0]   held;
    logic [4:0]   rn;
    logic         tail;

    s    = state_i;
    c    = '0;
    rp   = '0;
    held = 5'd0;
    rn   = 5'd0;
    tail = 1'b0;
    if (first_i) begin
      s.mode  = MODE_COPY;
      s.midx  = 5'd0;
      s.cont  = 3'd0;
      s.count = 8'd0;
    end

    unique case (s.mode)
      MODE_COPY: begin
        c    = copy_byte(s, byte_i, limit_i);
        s    = c.st;
        tail = c.emit;
      end
      MODE_TAG: begin
        if (byte_i == CH_NUL)     s.mode = MODE_DONE;
        else if (byte_i == CH_GT) s.mode = MODE_COPY;
      end
      MODE_SKIP: begin
        if (byte_i == CH_NUL) begin
          s.mode = MODE_DONE;
        end else if (byte_i == CH_LF) begin
          s.mode = MODE_MATCH;
          s.midx = 5'd1;
        end
      end
      MODE_MATCH: begin
        if (s.midx != 5'd0 && s.midx < 5'(MARKER_LEN) && byte_i == marker_byte(s.midx)) begin
          s.midx = s.midx + 5'd1;
          if (s.midx >= 5'(MARKER_LEN)) begin
            s.midx = 5'd0;
            s.mode = MODE_SKIP;
          end
        end else begin
          held   = s.midx;
          s.midx = 5'd0;
          s.mode = MODE_COPY;
          rp     = replay(s, held, limit_i);
          s      = rp.st;
          rn     = rp.n;
          if (s.mode == MODE_COPY) begin
            c    = copy_byte(s, byte_i, limit_i);
            s    = c.st;
            tail = c.emit;
          end
        end
      end
      default: s.mode = MODE_DONE;
    endcase

    if (last_i) begin
      if (s.mode == MODE_MATCH) begin
        held   = s.midx;
        s.midx = 5'd0;
        s.mode = MODE_COPY;
        rp     = replay(s, held, limit_i);
        s      = rp.st;
        if (rp.n != 5'd0) rn = rp.n;
      end
      s.mode = MODE_DONE;
      s.midx = 5'd0;
      s.cont = 3'd0;
    end

    state_o           = s;
    desc_o.replay_n   = rn;
    desc_o.tail_valid = tail;
    desc_o.tail_byte  = byte_i;
    desc_o.done       = (s.mode == MODE_DONE);
    desc_o.count      = s.count;
  end

endmodule

`default_nettype wire

// ===== src/msu_emit.sv =====
// Result register and serializer: one result per cycle while the receiver is ready.
`default_nettype none

module msu_emit
  import msu_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  result_desc_t desc_i,
  output logic         can_load_o,
  output logic         valid_o,
  input  logic         ready_i,
  output logic [7:0]   byte_o,
  output logic         byte_valid_o,
  output logic         last_o,
  output logic         done_o,
  output logic [7:0]   count_o
);

  result_desc_t desc_q;
  logic         valid_q;
  logic [4:0]   ptr_q;
  logic [4:0]   total;
  logic [4:0]   last_ptr;
  logic         pop;
  logic         pop_last;

  assign total    = desc_q.replay_n + 5'(desc_q.tail_valid);
  assign last_ptr = (total == 5'd0) ? 5'd0 : total - 5'd1;
  assign last_o   = (ptr_q == last_ptr);
  assign pop      = valid_q && ready_i;
  assign pop_last = pop && last_o;

  assign can_load_o = !valid_q || pop_last;
  assign valid_o    = valid_q;
  assign done_o     = desc_q.done;
  assign count_o    = desc_q.count;

  always_comb begin
    if (ptr_q < desc_q.replay_n) begin
      byte_o       = marker_byte(ptr_q + 5'd1);
      byte_valid_o = 1'b1;
    end else if (desc_q.tail_valid) begin
      byte_o       = desc_q.tail_byte;
      byte_valid_o = 1'b1;
    end else begin
      byte_o       = CH_NUL;
      byte_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ptr_q   <= 5'd0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      ptr_q   <= 5'd0;
    end else if (pop_last) begin
      valid_q <= 1'b0;
    end else if (pop) begin
      ptr_q <= ptr_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      desc_q <= desc_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/msu_checker.sv =====
// Port-level checks for the preview unit, bound to the top level.
`default_nettype none

module msu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // an empty result is the only result of its request and carries a zero byte
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
    else $error("empty result not alone or nonzero");

  // results of one request share count and done status
  a_run_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
    m_axis_tvalid && m_axis_tdata[15:8] == $past(m_axis_tdata[15:8]) &&
    m_axis_tuser[1] == $past(m_axis_tuser[1]))
    else $error("status changed within a run");

  // a run of several results carries copied bytes only
  a_run_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |-> m_axis_tuser[0])
    else $error("empty result inside a run");

endmodule

bind markup_strip_utf8_preview_unit msu_checker u_msu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== sim/markup_strip_utf8_preview_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the markup-stripping UTF-8 preview unit.
module markup_strip_utf8_preview_unit_tb;
  import msu_pkg::*;

  // One preview result as it leaves the unit, split into fields.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       preview_done;
    logic [7:0] char_count;
  } preview_item_t;

  // Attachment marker; letter k sits at bits [(17-k)*8 +: 8].
  localparam logic [MARKER_LEN*8-1:0] ATTACH_SEQ = "\nbeginbinaryattach";
  localparam int unsigned MAX_PER_BYTE = 18;   // cap on results kept for one text byte
  localparam int unsigned HOLD_CYCLES  = 300;  // long receiver hold-off
  localparam int unsigned MAX_PRINTS   = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] text_byte
  logic        s_axis_tuser;   // [0] first_byte
  logic        s_axis_tlast;   // last_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [7:0] out_byte, [15:8] char_count
  logic [1:0]  m_axis_tuser;   // [0] byte_valid, [1] preview_done
  logic        m_axis_tlast;   // run_last

  markup_strip_utf8_preview_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Parser shadow: the stripping state machine as the unit should run it.
  // ---------------------------------------------------------------------------
  mode_e       strip_mode;
  logic [4:0]  strip_midx;    // marker letters matched
  logic [2:0]  strip_cont;    // continuation bytes still owed
  logic [7:0]  strip_count;   // counted characters
  logic [7:0]  strip_limit;   // shadow of char_limit
  logic [7:0]  kept_bytes[$]; // bytes passed on by the current request

  preview_item_t pending_preview[$];  // results still owed by the unit

  int unsigned mismatch_count;
  int unsigned results_checked;
  int unsigned items_sent;
  int unsigned texts_sent;
  int unsigned limits_written;

  logic src_idle_en;
  logic sink_idle_en;
  logic sink_hold;
  int unsigned sink_gap;

  logic [7:0] text_buf[$];

  function automatic logic [7:0] attach_letter(int unsigned k);
    return ATTACH_SEQ[(MARKER_LEN - 1 - k) * 8 +: 8];
  endfunction

  // Character length from the lead byte's leading ones, 1..6.
  function automatic int unsigned utf8_span(logic [7:0] b);
    int unsigned n;
    n = 1;
    if (b[7:6] != 2'b11) return 1;
    while (n < 6 && b[7 - n]) n++;
    return n;
  endfunction

  task automatic keep_byte(input logic [7:0] b);
    if (kept_bytes.size() < MAX_PER_BYTE) kept_bytes.push_back(b);
  endtask

  // Copy-mode handling of one byte (also used for replayed marker letters).
  task automatic copy_text_byte(input logic [7:0] b);
    int unsigned span;
    if (strip_cont != 0) begin
      // zero inside a multibyte character ends the text
      if (b == CH_NUL) begin
        strip_cont = 0;
        strip_mode = MODE_DONE;
        return;
      end
      keep_byte(b);
      strip_cont--;
    end else begin
      // limit is only checked between characters
      if (strip_count >= strip_limit || b == CH_NUL) begin
        strip_mode = MODE_DONE;
        return;
      end
      if (b == CH_LT) begin
        strip_mode = MODE_TAG;
        return;
      end
      if (b == CH_LF) begin
        strip_mode = MODE_MATCH;
        strip_midx = 1;
        return;
      end
      if (b == CH_CR || b == CH_LBRACE || b == CH_RBRACE || b == CH_LBRACK ||
          b == CH_RBRACK)
        return;
      span = utf8_span(b);
      keep_byte(b);
      if (span > 1) begin
        if (strip_count != 8'hFF) strip_count++;
        strip_cont = 3'(span - 1);
      end else if (b == CH_SPACE) begin
        if (strip_count != 8'hFF) strip_count++;
      end
    end
    if (strip_mode == MODE_COPY && strip_cont == 0 && strip_count >= strip_limit)
      strip_mode = MODE_DONE;
  endtask

  // Held marker letters go back through copy mode as plain text.
  task automatic replay_letters(input int unsigned held);
    for (int unsigned k = 1; k < held && k < MARKER_LEN; k++)
      if (strip_mode == MODE_COPY) copy_text_byte(attach_letter(k));
  endtask

  task automatic parse_byte(input logic [7:0] b);
    int unsigned held;
    case (strip_mode)
      MODE_COPY: copy_text_byte(b);
      MODE_TAG: begin
        if (b == CH_NUL) strip_mode = MODE_DONE;
        else if (b == CH_GT) strip_mode = MODE_COPY;
      end
      MODE_SKIP: begin
        if (b == CH_NUL) strip_mode = MODE_DONE;
        else if (b == CH_LF) begin
          strip_mode = MODE_MATCH;
          strip_midx = 1;
        end
      end
      MODE_MATCH: begin
        if (strip_midx > 0 && strip_midx < MARKER_LEN && b == attach_letter(strip_midx)) begin
          strip_midx++;
          if (strip_midx >= MARKER_LEN) begin
            strip_midx = 0;
            strip_mode = MODE_SKIP;
          end
        end else begin
          held = strip_midx;
          strip_midx = 0;
          strip_mode = MODE_COPY;
          replay_letters(held);
          if (strip_mode == MODE_COPY) copy_text_byte(b);
        end
      end
      default: strip_mode = MODE_DONE;
    endcase
  endtask

  // Work out and queue every result one accepted text byte causes.
  task automatic predict_preview(input logic [7:0] b, input logic first, input logic last);
    int unsigned n;
    int unsigned held;
    preview_item_t r;
    kept_bytes.delete();
    if (first) begin
      strip_mode  = MODE_COPY;
      strip_midx  = 0;
      strip_cont  = 0;
      strip_count = 0;
    end
    parse_byte(b);
    if (last) begin
      // text ends mid-match: letters held so far are still passed on
      if (strip_mode == MODE_MATCH) begin
        held = strip_midx;
        strip_midx = 0;
        strip_mode = MODE_COPY;
        replay_letters(held);
      end
      strip_mode = MODE_DONE;
      strip_midx = 0;
      strip_cont = 0;
    end
    n = (kept_bytes.size() > 0) ? kept_bytes.size() : 1;
    for (int unsigned k = 0; k < n; k++) begin
      r.out_byte     = (kept_bytes.size() > 0) ? kept_bytes[k] : 8'h00;
      r.byte_valid   = (kept_bytes.size() > 0);
      r.run_last     = (k == n - 1);
      r.preview_done = (strip_mode == MODE_DONE);
      r.char_count   = strip_count;
      pending_preview.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, long hold-off, field-by-field compare.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("%0t ns: mismatch in %s: got %h, expected %h", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin
    preview_item_t want;
    // values sampled here are the ones from before this edge
    if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      if (pending_preview.size() == 0) begin
        report_mismatch("result with nothing pending", m_axis_tdata[7:0], 8'h00);
      end else begin
        want = pending_preview.pop_front();
        results_checked++;
        if (m_axis_tdata[7:0] !== want.out_byte)
          report_mismatch("out_byte", m_axis_tdata[7:0], want.out_byte);
        if (m_axis_tuser[0] !== want.byte_valid)
          report_mismatch("byte_valid", {7'd0, m_axis_tuser[0]}, {7'd0, want.byte_valid});
        if (m_axis_tlast !== want.run_last)
          report_mismatch("run_last", {7'd0, m_axis_tlast}, {7'd0, want.run_last});
        if (m_axis_tuser[1] !== want.preview_done)
          report_mismatch("preview_done", {7'd0, m_axis_tuser[1]},
                          {7'd0, want.preview_done});
        if (m_axis_tdata[15:8] !== want.char_count)
          report_mismatch("char_count", m_axis_tdata[15:8], want.char_count);
      end
    end
    // ready: held off on request, else random stall bursts
    if (sink_hold) begin
      m_axis_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
      sink_gap <= $urandom_range(0, 13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side.
  // ---------------------------------------------------------------------------
  // Offer one text byte, optionally after an idle burst, and wait for acceptance.
  // tvalid stays high afterwards so back-to-back requests need no extra edge.
  task automatic send_text_byte(input logic [7:0] b, input logic first, input logic last);
    int unsigned gap;
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (s_axis_tready !== 1'b1) @(posedge clk_i);
    predict_preview(b, first, last);
    items_sent++;
  endtask

  // Stop offering, let every owed result come back, then allow for latency.
  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_preview.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_char_limit(input logic [7:0] value);
    settle_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    strip_limit = value;
    limits_written++;
  endtask

  // Send text_buf as one text; it ends on tlast, on a zero byte, or just stops
  // and is cut off by the next text's first_byte.
  task automatic play_text();
    int unsigned ending;
    ending = $urandom_range(0, 3);
    if (ending == 2) text_buf.push_back(CH_NUL);
    foreach (text_buf[i])
      send_text_byte(text_buf[i], i == 0, ending < 2 && i == text_buf.size() - 1);
    texts_sent++;
  endtask

  // Build a mostly well-formed random text: words, spaces, tags, UTF-8 runs,
  // full and partial attachment markers, dropped control bytes and a bit of noise.
  task automatic build_text(input int unsigned target);
    int unsigned n;
    logic [7:0] ch;
    text_buf.delete();
    while (text_buf.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          repeat ($urandom_range(1, 6)) begin
            ch = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(8'h41, 8'h5A))
                                             : 8'($urandom_range(8'h61, 8'h7A));
            text_buf.push_back(ch);
          end
        end
        3: text_buf.push_back(CH_SPACE);
        4: begin
          text_buf.push_back(CH_LT);
          repeat ($urandom_range(0, 4)) begin
            ch = 8'($urandom_range(8'h21, 8'h7E));
            text_buf.push_back(ch);
          end
          text_buf.push_back(CH_GT);
        end
        5: begin
          n = $urandom_range(2, 6);
          ch = 8'(((8'hFF << (8 - n)) & 8'hFF) | ($urandom() & (8'hFF >> (n + 1))));
          if ($urandom_range(0, 7) == 0) begin
            n = 6;
            ch = 8'(8'hFE | $urandom_range(0, 1));  // lead with too many ones
          end
          text_buf.push_back(ch);
          repeat (n - 1) begin
            ch = 8'(8'h80 | $urandom_range(0, 63));
            text_buf.push_back(ch);
          end
        end
        6, 7: begin
          n = $urandom_range(0, MARKER_LEN - 1);
          if ($urandom_range(0, 2) == 0) n = MARKER_LEN - 1;
          text_buf.push_back(CH_LF);
          for (int unsigned k = 1; k <= n; k++) text_buf.push_back(attach_letter(k));
          if (n == MARKER_LEN - 1) begin
            // attachment line content, usually closed by a newline
            repeat ($urandom_range(0, 5)) begin
              ch = 8'($urandom_range(8'h20, 8'h7E));
              text_buf.push_back(ch);
            end
            if ($urandom_range(0, 2) != 0) text_buf.push_back(CH_LF);
          end else begin
            ch = 8'($urandom_range(8'h20, 8'h7E));
            text_buf.push_back(ch);
          end
        end
        8: begin
          case ($urandom_range(0, 4))
            0: ch = CH_CR;
            1: ch = CH_LBRACE;
            2: ch = CH_RBRACE;
            3: ch = CH_LBRACK;
            default: ch = CH_RBRACK;
          endcase
          text_buf.push_back(ch);
        end
        default: begin
          ch = 8'($urandom_range(0, 255));
          text_buf.push_back(ch);
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------
  // Reset limit of 35; tag drop, control and bracket drop, stray continuation,
  // two-byte character, then zero inside a six-byte character.
  task automatic test_tags_and_controls();
    send_text_byte(CH_LT, 1'b1, 1'b0);
    send_text_byte(8'h78, 1'b0, 1'b0);
    send_text_byte(CH_GT, 1'b0, 1'b0);
    send_text_byte(8'h48, 1'b0, 1'b0);
    send_text_byte(CH_CR, 1'b0, 1'b0);
    send_text_byte(CH_LBRACE, 1'b0, 1'b0);
    send_text_byte(CH_RBRACE, 1'b0, 1'b0);
    send_text_byte(CH_LBRACK, 1'b0, 1'b0);
    send_text_byte(CH_RBRACK, 1'b0, 1'b0);
    send_text_byte(CH_SPACE, 1'b0, 1'b0);
    send_text_byte(8'h80, 1'b0, 1'b0);
    send_text_byte(8'hC3, 1'b0, 1'b0);
    send_text_byte(8'hA9, 1'b0, 1'b0);
    send_text_byte(8'hFF, 1'b0, 1'b0);
    send_text_byte(CH_NUL, 1'b0, 1'b0);
  endtask

  // Full marker starts a skip; a broken match replays its letters; a text that
  // ends mid-match replays too; bytes after done are ignored.
  task automatic test_attachment_marker();
    send_text_byte(8'h61, 1'b1, 1'b0);
    send_text_byte(CH_LF, 1'b0, 1'b0);
    for (int unsigned k = 1; k < MARKER_LEN; k++)
      send_text_byte(attach_letter(k), 1'b0, 1'b0);
    send_text_byte(8'h7A, 1'b0, 1'b0);
    send_text_byte(CH_LF, 1'b0, 1'b0);
    send_text_byte(attach_letter(1), 1'b0, 1'b0);
    send_text_byte(attach_letter(2), 1'b0, 1'b0);
    send_text_byte(8'h58, 1'b0, 1'b0);
    send_text_byte(CH_LF, 1'b0, 1'b0);
    send_text_byte(attach_letter(1), 1'b0, 1'b1);
    send_text_byte(8'h71, 1'b0, 1'b0);
  endtask

  // Limit hit inside a character, limits 1 and 0, and the top limit of 255.
  task automatic test_char_limit();
    write_char_limit(8'd2);
    send_text_byte(CH_SPACE, 1'b1, 1'b0);
    send_text_byte(8'hE2, 1'b0, 1'b0);
    send_text_byte(8'h82, 1'b0, 1'b0);
    send_text_byte(8'hAC, 1'b0, 1'b0);
    send_text_byte(8'h79, 1'b0, 1'b0);
    write_char_limit(8'd1);
    send_text_byte(8'h6B, 1'b1, 1'b0);
    send_text_byte(CH_SPACE, 1'b0, 1'b0);
    write_char_limit(8'd0);
    send_text_byte(8'h61, 1'b1, 1'b0);
    send_text_byte(8'h62, 1'b0, 1'b1);
    write_char_limit(8'd255);
    send_text_byte(8'hF0, 1'b1, 1'b0);
    send_text_byte(8'h9F, 1'b0, 1'b0);
    send_text_byte(8'h98, 1'b0, 1'b0);
    send_text_byte(8'h80, 1'b0, 1'b0);
    send_text_byte(CH_SPACE, 1'b0, 1'b0);
    send_text_byte(8'h5A, 1'b0, 1'b1);
  endtask

  // Receiver holds off while the sender keeps offering broken markers, each ending in a
  // byte that costs eleven results, so the unit backs up and drops tready.
  task automatic test_sink_backpressure();
    write_char_limit(CHAR_LIMIT_RESET);
    src_idle_en = 1'b0;
    fork
      begin
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        sink_hold <= 1'b0;
      end
    join_none
    repeat (3) begin
      send_text_byte(CH_LF, texts_sent == 0, 1'b0);
      for (int unsigned k = 1; k <= 10; k++) send_text_byte(attach_letter(k), 1'b0, 1'b0);
      send_text_byte(8'h51, 1'b0, 1'b0);
    end
    send_text_byte(8'h78, 1'b0, 1'b1);
    texts_sent++;
    src_idle_en = 1'b1;
    settle_idle();
  endtask

  task automatic random_phase(input logic [7:0] limit, input int unsigned budget,
                              input logic idle);
    int unsigned start;
    write_char_limit(limit);
    src_idle_en  = idle;
    sink_idle_en = idle;
    start = items_sent;
    while (items_sent - start < budget) begin
      build_text($urandom_range(4, 30));
      play_text();
    end
  endtask

  // Several limit settings; the last phase runs flat out with no idling.
  task automatic test_random_texts();
    random_phase(8'($urandom_range(8, 40)), 40, 1'b1);
    random_phase(8'd255, 30, 1'b1);
    random_phase(8'($urandom_range(2, 6)), 20, 1'b1);
    random_phase(CHAR_LIMIT_RESET, 40, 1'b0);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 8'h00;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    src_idle_en   = 1'b1;
    sink_idle_en  = 1'b1;
    sink_hold     = 1'b0;
    sink_gap      = 0;
    strip_mode    = MODE_COPY;
    strip_midx    = 0;
    strip_cont    = 0;
    strip_count   = 0;
    strip_limit   = CHAR_LIMIT_RESET;
    mismatch_count  = 0;
    results_checked = 0;
    items_sent      = 0;
    texts_sent      = 0;
    limits_written  = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_tags_and_controls();
    test_attachment_marker();
    test_char_limit();
    test_sink_backpressure();
    test_random_texts();

    settle_idle();
    repeat (16) @(posedge clk_i);

    $display("Ran %0d text bytes in about %0d texts; %0d preview results compared.",
             items_sent, texts_sent, results_checked);
    $display("Covered tags, dropped bytes, UTF-8, marker skips and replays, %0d limit writes.",
             limits_written);
    if (mismatch_count == 0 && pending_preview.size() == 0) begin
      $display("PASS markup_strip_utf8_preview_unit");
    end else begin
      $display("FAIL markup_strip_utf8_preview_unit");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run (every byte at the most results, each
  // behind the longest stall, plus the hold-off).
  initial begin
    #20000000;
    $display("Timed out with %0d results still pending.", pending_preview.size());
    $display("FAIL markup_strip_utf8_preview_unit");
    $finish;
  end

endmodule
